@@ rtl/crast_pkg.sv @@
// Shared types and constants for the circle rasterizer.
package crast_pkg;

  localparam int DEC_W = 16;

  // Draw mode register codes; the fourth code acts as the Bresenham outline mode.
  typedef enum logic [1:0] {
    MODE_BRES_OUTLINE = 2'd0,
    MODE_BRES_FILL    = 2'd1,
    MODE_MIDPOINT     = 2'd2
  } draw_mode_t;

  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_STEP  = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    JOB_POINTS = 2'd0,
    JOB_SPANS  = 2'd1,
    JOB_DONE   = 2'd2
  } job_kind_t;

  localparam logic [DEC_W-1:0] BRES_INIT      = 16'd3;
  localparam logic [DEC_W-1:0] BRES_STEP_KEEP = 16'd6;
  localparam logic [DEC_W-1:0] BRES_STEP_DIAG = 16'd10;
  localparam logic [DEC_W-1:0] MID_INIT       = 16'd1;
  localparam logic [DEC_W-1:0] MID_STEP_KEEP  = 16'd3;
  localparam logic [DEC_W-1:0] MID_STEP_DIAG  = 16'd5;

  localparam int OUTLINE_BEATS = 8;
  localparam int SPAN_BEATS    = 4;

endpackage

@@ rtl/crast_if.sv @@
// Valid/ready channel interfaces for circle items and raster results.
interface crast_in_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-2:0] radius;

  modport source (output valid, kind, center_x, center_y, radius, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

interface crast_out_if #(
  parameter int COORD_BITS = 12
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] left_x;
  logic signed [COORD_BITS+1:0] right_x;
  logic signed [COORD_BITS+1:0] row_y;
  logic                         finished;
  logic                         last;

  modport source (output valid, left_x, right_x, row_y, finished, last, input ready);
  modport sink   (input valid, left_x, right_x, row_y, finished, last, output ready);
endinterface

@@ rtl/crast_front.sv @@
// Front end: takes items, holds the circle state and queues one job per step.
module crast_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_wr_en,
  input  logic [1:0]              cfg_wr_data,
  crast_in_if.sink                in_ch,
  input  logic                    q_full,
  output logic                    job_push,
  output logic [4*COORD_BITS-1:0] job_data
);
  import crast_pkg::*;

  localparam int CB = COORD_BITS;

  typedef struct packed {
    job_kind_t       kind;
    logic [CB-1:0]   cx;
    logic [CB-1:0]   cy;
    logic [CB-2:0]   x;
    logic [CB-2:0]   y;
  } job_t;

  logic [1:0]       mode_r;
  logic             active_r, active_nxt;
  logic [CB-1:0]    cx_r, cx_nxt;
  logic [CB-1:0]    cy_r, cy_nxt;
  logic [CB-2:0]    x_r, x_nxt;
  logic [CB-2:0]    y_r, y_nxt;
  logic [DEC_W-1:0] dec_r, dec_nxt;

  logic             accept;
  logic             is_fill;
  logic             is_mid;
  logic             finish_now;
  logic             diag;
  logic [DEC_W-1:0] x16;
  logic [DEC_W-1:0] y16;
  logic [DEC_W-1:0] dec_step;
  logic signed [CB:0] x_inc;
  logic signed [CB:0] y_dec;
  job_t             job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BRES_OUTLINE;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_comb begin
    is_fill = 1'b0;
    is_mid  = 1'b0;
    case (mode_r)
      MODE_BRES_FILL: is_fill = 1'b1;
      MODE_MIDPOINT:  is_mid  = 1'b1;
      default:        ;
    endcase
  end

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // A step past the end, or with no circle loaded, only reports completion.
  assign finish_now = !active_r || (x_r > y_r);

  assign x16  = DEC_W'(x_r);
  assign y16  = DEC_W'(y_r);
  assign diag = !dec_r[DEC_W-1];

  always_comb begin
    if (is_mid) begin
      if (diag) dec_step = dec_r + (x16 << 1) + MID_STEP_DIAG - (y16 << 1);
      else      dec_step = dec_r + (x16 << 1) + MID_STEP_KEEP;
    end else begin
      if (diag) dec_step = dec_r + ((x16 - y16) << 2) + BRES_STEP_DIAG;
      else      dec_step = dec_r + (x16 << 2) + BRES_STEP_KEEP;
    end
  end

  assign x_inc = $signed({2'b00, x_r}) + $signed((CB+1)'(1));
  assign y_dec = $signed({2'b00, y_r}) - $signed((CB+1)'(diag));

  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    job_push   = 1'b0;
    job.kind   = finish_now ? JOB_DONE : (is_fill ? JOB_SPANS : JOB_POINTS);
    job.cx     = cx_r;
    job.cy     = cy_r;
    job.x      = x_r;
    job.y      = y_r;
    if (accept) begin
      if (in_ch.kind == KIND_BEGIN) begin
        active_nxt = 1'b1;
        cx_nxt     = in_ch.center_x;
        cy_nxt     = in_ch.center_y;
        x_nxt      = '0;
        y_nxt      = in_ch.radius;
        if (is_mid) dec_nxt = MID_INIT - DEC_W'(in_ch.radius);
        else        dec_nxt = BRES_INIT - (DEC_W'(in_ch.radius) << 1);
      end else begin
        job_push = 1'b1;
        if (finish_now) begin
          active_nxt = 1'b0;
        end else begin
          dec_nxt = dec_step;
          x_nxt   = x_inc[CB-2:0];
          if (x_inc > y_dec) begin
            active_nxt = 1'b0;
            y_nxt      = '0;
          end else begin
            y_nxt = y_dec[CB-2:0];
          end
        end
      end
    end
  end

  assign job_data = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      x_r   <= '0;
      y_r   <= '0;
      dec_r <= '0;
    end else begin
      cx_r  <= cx_nxt;
      cy_r  <= cy_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      dec_r <= dec_nxt;
    end
  end

  a_active_in_octant: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (x_r <= y_r))
    else $error("circle state left the octant while active");

  a_push_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> (in_ch.valid && in_ch.ready && in_ch.kind == KIND_STEP))
    else $error("job queued without an accepted step beat");

  a_begin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.kind == KIND_BEGIN) |=> active_r)
    else $error("begin beat did not start a circle");

endmodule

@@ rtl/crast_queue.sv @@
// Small register FIFO that decouples the front end from the result sequencer.
module crast_queue #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] head_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_data = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ rtl/crast_back.sv @@
// Back end: expands one queued job into its point or span beats.
module crast_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  logic [4*COORD_BITS-1:0] q_data,
  output logic                    q_pop,
  crast_out_if.source             out_ch
);
  import crast_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int OW = COORD_BITS + 2;

  typedef struct packed {
    job_kind_t       kind;
    logic [CB-1:0]   cx;
    logic [CB-1:0]   cy;
    logic [CB-2:0]   x;
    logic [CB-2:0]   y;
  } job_t;

  job_t           job_r;
  logic           busy_r;
  logic [2:0]     idx_r;
  logic           out_valid_r;
  logic signed [OW-1:0] left_x_r;
  logic signed [OW-1:0] right_x_r;
  logic signed [OW-1:0] row_y_r;
  logic           finished_r;
  logic           last_r;

  logic           slot_free;
  logic           emit;
  logic           last_beat;
  logic           is_spans;
  logic           swap;
  logic           row_neg;
  logic [CB-2:0]  off_a;
  logic [CB-2:0]  off_b;
  logic signed [OW-1:0] cx_w, cy_w, a_w, b_w;
  logic signed [OW-1:0] col_plus, col_minus, row_plus, row_minus;
  logic signed [OW-1:0] lx, rx, ry;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit      = busy_r && slot_free;
  assign is_spans  = (job_r.kind == JOB_SPANS);

  always_comb begin
    case (job_r.kind)
      JOB_SPANS:  last_beat = (idx_r == 3'(SPAN_BEATS - 1));
      JOB_POINTS: last_beat = (idx_r == 3'(OUTLINE_BEATS - 1));
      default:    last_beat = 1'b1;
    endcase
  end

  // The next job is taken as the last beat of the current one leaves.
  assign q_pop = q_valid && (!busy_r || (emit && last_beat));

  // Beats four to seven of an outline, and the last two spans, use the swapped octant.
  assign swap    = is_spans ? idx_r[1] : idx_r[2];
  assign row_neg = is_spans ? idx_r[0] : idx_r[1];
  assign off_a   = swap ? job_r.y : job_r.x;
  assign off_b   = swap ? job_r.x : job_r.y;

  assign cx_w = $signed({2'b00, job_r.cx});
  assign cy_w = $signed({2'b00, job_r.cy});
  assign a_w  = $signed({3'b000, off_a});
  assign b_w  = $signed({3'b000, off_b});

  assign col_plus  = cx_w + a_w;
  assign col_minus = cx_w - a_w;
  assign row_plus  = cy_w + b_w;
  assign row_minus = cy_w - b_w;

  always_comb begin
    case (job_r.kind)
      JOB_SPANS: begin
        lx = col_minus;
        rx = col_plus;
        ry = row_neg ? row_minus : row_plus;
      end
      JOB_POINTS: begin
        lx = idx_r[0] ? col_minus : col_plus;
        rx = lx;
        ry = row_neg ? row_minus : row_plus;
      end
      default: begin
        lx = '0;
        rx = '0;
        ry = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (emit && last_beat) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 1'b1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if (emit) begin
      left_x_r   <= lx;
      right_x_r  <= rx;
      row_y_r    <= ry;
      finished_r <= (job_r.kind == JOB_DONE);
      last_r     <= last_beat;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.left_x   = left_x_r;
  assign out_ch.right_x  = right_x_r;
  assign out_ch.row_y    = row_y_r;
  assign out_ch.finished = finished_r;
  assign out_ch.last     = last_r;

  a_span_index: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && job_r.kind == JOB_SPANS) |-> (idx_r < 3'(SPAN_BEATS)))
    else $error("span job ran past its fourth beat");

  a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && job_r.kind == JOB_DONE) |-> (idx_r == '0))
    else $error("done job produced more than one beat");

  a_pop_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("job taken from an empty queue");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last_beat && !q_pop) |=> !busy_r)
    else $error("sequencer stayed busy after the last beat");

endmodule

@@ rtl/circle_rasterizer.sv @@
// An accepted step is queued as a job, loaded into the sequencer's job register and
// expanded into the output register, one result beat per cycle while out_ch.ready
// holds: eight beats per step in the outline modes, four in fill mode, one for the
// done beat, set by the result sequencer. A begin beat yields no result; a two-entry
// job queue lets the front end take new beats while the sequencer drains. Reset is
// synchronous, active-low; it clears circle state, queue, sequencer, mode to outline.
module circle_rasterizer #(
  parameter int COORD_BITS  = 12,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  crast_in_if.sink    in_ch,
  crast_out_if.source out_ch
);
  import crast_pkg::*;

  localparam int JOB_W = 4 * COORD_BITS;

  logic             q_full;
  logic             q_not_empty;
  logic             job_push;
  logic             job_pop;
  logic [JOB_W-1:0] job_in;
  logic [JOB_W-1:0] job_head;

  crast_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .job_push    (job_push),
    .job_data    (job_in)
  );

  crast_queue #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (job_in),
    .pop       (job_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_data (job_head)
  );

  crast_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_data  (job_head),
    .q_pop   (job_pop),
    .out_ch  (out_ch)
  );

endmodule
